>>> rtl/core/jila_pkg.sv
// ----------------------------------------------------------------------------
// jila_pkg
// Shared types and constants of the integer and long ALU.
// ----------------------------------------------------------------------------
package jila_pkg;

	localparam logic [4:0] OP_LONG_BASE    = 5'd15;
	localparam logic [4:0] OP_LAST         = 5'd29;
	localparam logic [5:0] INT_SHIFT_MASK  = 6'h1F;
	localparam logic [5:0] LONG_SHIFT_MASK = 6'h3F;
	localparam int         DIV_STAGES      = 64;

	typedef enum logic [3:0] {
		K_ADD, K_SUB, K_MUL, K_AND, K_OR, K_XOR, K_DIV, K_REM,
		K_SHL, K_SHR, K_USHR, K_NEG, K_ABS, K_MIN, K_MAX
	} kind_t;

	typedef struct packed {
		logic [4:0]         operation;
		logic signed [63:0] operand_a;
		logic signed [63:0] operand_b;
	} in_word_t;

	typedef struct packed {
		logic signed [63:0] result_value;
		logic               arith_exception;
	} out_word_t;

	typedef struct packed {
		logic        valid;
		kind_t       kind;
		logic        is_long;
		logic        bad_op;
		logic        div_zero;
		logic        neg_a;
		logic        neg_b;
		logic [63:0] res;
	} side_t;

endpackage

>>> rtl/core/jila_front.sv
// ----------------------------------------------------------------------------
// jila_front
// Decode, simple operations and the partial-product multiplier (three stages).
// ----------------------------------------------------------------------------
module jila_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_valid,
	input  jila_pkg::in_word_t in_word,
	output jila_pkg::side_t   side,
	output logic [63:0]       dividend,
	output logic [63:0]       divisor
);

	logic               v_s1, long_s1, bad_s1;
	jila_pkg::kind_t    kind_s1;
	logic signed [63:0] a_s1, b_s1;
	logic [5:0]         sh_s1;

	logic               v_s2, long_s2, bad_s2, zero_s2, na_s2, nb_s2;
	jila_pkg::kind_t    kind_s2;
	logic [63:0]        simple_s2, ma_s2, mb_s2, pll_s2;
	logic [31:0]        plh_s2, phl_s2;

	jila_pkg::side_t    side_s3;
	logic [63:0]        ma_s3, mb_s3;

	logic               d_long, d_bad;
	logic [4:0]         d_kind5;
	logic signed [63:0] d_a, d_b;
	logic [63:0]        simple, ushr_src;

	always_comb begin
		d_long  = in_word.operation >= jila_pkg::OP_LONG_BASE;
		d_bad   = in_word.operation > jila_pkg::OP_LAST;
		d_kind5 = d_long ? in_word.operation - jila_pkg::OP_LONG_BASE : in_word.operation;
		d_a = d_long ? in_word.operand_a
			: {{32{in_word.operand_a[31]}}, in_word.operand_a[31:0]};
		d_b = d_long ? in_word.operand_b
			: {{32{in_word.operand_b[31]}}, in_word.operand_b[31:0]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			long_s1 <= d_long;
			bad_s1  <= d_bad;
			kind_s1 <= jila_pkg::kind_t'(d_kind5[3:0]);
			a_s1    <= d_a;
			b_s1    <= d_b;
			sh_s1   <= in_word.operand_b[5:0]
				& (d_long ? jila_pkg::LONG_SHIFT_MASK : jila_pkg::INT_SHIFT_MASK);
		end
	end

	always_comb begin
		ushr_src = long_s1 ? a_s1 : {32'b0, a_s1[31:0]};
		case (kind_s1)
			jila_pkg::K_ADD:  simple = a_s1 + b_s1;
			jila_pkg::K_SUB:  simple = a_s1 - b_s1;
			jila_pkg::K_AND:  simple = a_s1 & b_s1;
			jila_pkg::K_OR:   simple = a_s1 | b_s1;
			jila_pkg::K_XOR:  simple = a_s1 ^ b_s1;
			jila_pkg::K_SHL:  simple = a_s1 << sh_s1;
			jila_pkg::K_SHR:  simple = a_s1 >>> sh_s1;
			jila_pkg::K_USHR: simple = ushr_src >> sh_s1;
			jila_pkg::K_NEG:  simple = 64'd0 - a_s1;
			jila_pkg::K_ABS:  simple = a_s1[63] ? 64'd0 - a_s1 : a_s1;
			jila_pkg::K_MIN:  simple = (b_s1 < a_s1) ? b_s1 : a_s1;
			jila_pkg::K_MAX:  simple = (a_s1 < b_s1) ? b_s1 : a_s1;
			default:          simple = 64'd0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			long_s2   <= long_s1;
			bad_s2    <= bad_s1;
			kind_s2   <= kind_s1;
			simple_s2 <= simple;
			pll_s2    <= a_s1[31:0] * b_s1[31:0];
			plh_s2    <= 32'(a_s1[31:0] * b_s1[63:32]);
			phl_s2    <= 32'(a_s1[63:32] * b_s1[31:0]);
			na_s2     <= a_s1[63];
			nb_s2     <= b_s1[63];
			ma_s2     <= a_s1[63] ? 64'd0 - a_s1 : a_s1;
			mb_s2     <= b_s1[63] ? 64'd0 - b_s1 : b_s1;
			zero_s2   <= b_s1 == 64'sd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_s3 <= '0;
		end else if (en) begin
			side_s3.valid    <= v_s2;
			side_s3.kind     <= kind_s2;
			side_s3.is_long  <= long_s2;
			side_s3.bad_op   <= bad_s2;
			side_s3.div_zero <= zero_s2;
			side_s3.neg_a    <= na_s2;
			side_s3.neg_b    <= nb_s2;
			side_s3.res      <= (kind_s2 == jila_pkg::K_MUL)
				? pll_s2 + {plh_s2 + phl_s2, 32'b0} : simple_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ma_s3 <= ma_s2;
			mb_s3 <= mb_s2;
		end
	end

	assign side     = side_s3;
	assign dividend = ma_s3;
	assign divisor  = mb_s3;

endmodule

>>> rtl/core/jila_div_pipe.sv
// ----------------------------------------------------------------------------
// jila_div_pipe
// Unsigned restoring divider, one quotient bit per pipeline stage.
// ----------------------------------------------------------------------------
module jila_div_pipe (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  jila_pkg::side_t side_in,
	input  logic [63:0]     dividend,
	input  logic [63:0]     divisor,
	output jila_pkg::side_t side_out,
	output logic [63:0]     quotient,
	output logic [63:0]     remainder
);

	localparam int N = jila_pkg::DIV_STAGES;

	jila_pkg::side_t side_s [N];
	logic [63:0]     rem_s [N];
	logic [63:0]     quo_s [N];
	logic [63:0]     dvs_s [N];

	jila_pkg::side_t side_n [N];
	logic [63:0]     rem_n [N];
	logic [63:0]     quo_n [N];
	logic [63:0]     dvs_n [N];

	always_comb begin
		logic [63:0] rp, qp, dp;
		logic [64:0] trial, diff;
		for (int i = 0; i < N; i++) begin
			if (i == 0) begin
				side_n[i] = side_in;
				rp = 64'd0;
				qp = dividend;
				dp = divisor;
			end else begin
				side_n[i] = side_s[i-1];
				rp = rem_s[i-1];
				qp = quo_s[i-1];
				dp = dvs_s[i-1];
			end
			trial = {rp, qp[63]};
			diff  = trial - {1'b0, dp};
			if (!diff[64]) begin
				rem_n[i] = diff[63:0];
				quo_n[i] = {qp[62:0], 1'b1};
			end else begin
				rem_n[i] = trial[63:0];
				quo_n[i] = {qp[62:0], 1'b0};
			end
			dvs_n[i] = dp;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < N; i++) begin
				side_s[i] <= '0;
			end
		end else if (en) begin
			for (int i = 0; i < N; i++) begin
				side_s[i] <= side_n[i];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < N; i++) begin
				rem_s[i] <= rem_n[i];
				quo_s[i] <= quo_n[i];
				dvs_s[i] <= dvs_n[i];
			end
		end
	end

	assign side_out  = side_s[N-1];
	assign quotient  = quo_s[N-1];
	assign remainder = rem_s[N-1];

endmodule

>>> rtl/core/jvm_integer_long_alu_core.sv
// ----------------------------------------------------------------------------
// jvm_integer_long_alu_core
// Java bytecode int and long ALU, fully pipelined.
// ----------------------------------------------------------------------------
// An operation word (code, operand A, operand B) enters on the in channel and
// one result word (value, exception flag) leaves on the out channel, in order.
// Every operation passes, from acceptance to the result being shown, through
// three front stages (decode, simple operations and partial products, product
// sum), 64 divider stages retiring one quotient bit each, and the output
// register. All operations take this one path, so results never reorder.
// Throughput is one word a cycle while the output does not stall.
// The whole pipeline advances together; when the receiver holds out_ready low
// while a result is shown, every stage holds and in_ready falls, so nothing
// is lost or repeated. In-flight results are kept until taken.
// Reset clears every valid bit; the pipeline is empty and in_ready is high.
// ----------------------------------------------------------------------------
module jvm_integer_long_alu_core (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  jila_pkg::in_word_t  in_word,
	output logic                out_valid,
	input  logic                out_ready,
	output jila_pkg::out_word_t out_word
);

	logic            en;
	jila_pkg::side_t f_side, d_side;
	logic [63:0]     f_dvd, f_dvs, d_quo, d_rem;
	logic [63:0]     r;
	logic            is_div, exc;

	logic                out_valid_q;
	jila_pkg::out_word_t out_word_q;

	assign en       = !out_valid_q || out_ready;
	assign in_ready = en;

	jila_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (in_valid),
		.in_word  (in_word),
		.side     (f_side),
		.dividend (f_dvd),
		.divisor  (f_dvs)
	);

	jila_div_pipe u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.side_in   (f_side),
		.dividend  (f_dvd),
		.divisor   (f_dvs),
		.side_out  (d_side),
		.quotient  (d_quo),
		.remainder (d_rem)
	);

	always_comb begin
		is_div = d_side.kind inside {jila_pkg::K_DIV, jila_pkg::K_REM};
		case (d_side.kind)
			jila_pkg::K_DIV: r = (d_side.neg_a ^ d_side.neg_b) ? 64'd0 - d_quo : d_quo;
			jila_pkg::K_REM: r = d_side.neg_a ? 64'd0 - d_rem : d_rem;
			default:         r = d_side.res;
		endcase
		exc = is_div && d_side.div_zero && !d_side.bad_op;
		if (d_side.bad_op || exc) begin
			r = 64'd0;
		end
		if (!d_side.is_long) begin
			r = {{32{r[31]}}, r[31:0]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= d_side.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_word_q.result_value    <= r;
			out_word_q.arith_exception <= exc;
		end
	end

	assign out_valid = out_valid_q;
	assign out_word  = out_word_q;

	a_exc_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_word.arith_exception |-> out_word.result_value == 64'sd0)
		else $error("exception result is not zero");

	a_ready_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && !out_ready)
		else $error("input stalled without an output stall");

	a_div_rem: assert property (@(posedge clk) disable iff (!arst_n)
		d_side.valid && is_div && !d_side.div_zero && !d_side.bad_op
		|-> d_rem < u_div.dvs_s[jila_pkg::DIV_STAGES-1])
		else $error("divider remainder out of range");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(d_side) && $stable(d_quo))
		else $error("pipeline moved during a stall");

endmodule

>>> dv/jvm_integer_long_alu_checker.sv
// ----------------------------------------------------------------------------
// jvm_integer_long_alu_checker
// Watches both channels of the ALU, predicts each result word from the
// accepted operation word and compares it with what the block returns.
// ----------------------------------------------------------------------------
module jvm_integer_long_alu_checker (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic                in_ready,
	input  jila_pkg::in_word_t  in_word,
	input  logic                out_valid,
	input  logic                out_ready,
	input  jila_pkg::out_word_t out_word,
	output int                  errors,
	output int                  pending
);
	timeunit 1ns;
	timeprecision 1ps;

	jila_pkg::out_word_t awaited_results[$];

	function automatic logic [63:0] sext_low(logic [63:0] x);
		return {{32{x[31]}}, x[31:0]};
	endfunction

	function automatic logic [63:0] quot_or_rem(logic [63:0] a, logic [63:0] b, bit want_rem);
		logic [63:0] ma, mb, q, r;
		ma = a[63] ? -a : a;
		mb = b[63] ? -b : b;
		q = ma / mb;
		r = ma % mb;
		if (want_rem)
			return a[63] ? -r : r;
		return (a[63] != b[63]) ? -q : q;
	endfunction

	function automatic jila_pkg::out_word_t alu_result(jila_pkg::in_word_t w);
		jila_pkg::out_word_t o;
		logic [63:0] a, b, r;
		logic [5:0] sh;
		logic [4:0] kd;
		bit is_long;
		jila_pkg::kind_t k;
		o = '0;
		if (w.operation > jila_pkg::OP_LAST)
			return o;
		is_long = w.operation >= jila_pkg::OP_LONG_BASE;
		kd = is_long ? w.operation - jila_pkg::OP_LONG_BASE : w.operation;
		k = jila_pkg::kind_t'(kd[3:0]);
		a = is_long ? w.operand_a : sext_low(w.operand_a);
		b = is_long ? w.operand_b : sext_low(w.operand_b);
		sh = w.operand_b[5:0]
			& (is_long ? jila_pkg::LONG_SHIFT_MASK : jila_pkg::INT_SHIFT_MASK);
		r = '0;
		case (k)
			jila_pkg::K_ADD: r = a + b;
			jila_pkg::K_SUB: r = a - b;
			jila_pkg::K_MUL: r = a * b;
			jila_pkg::K_AND: r = a & b;
			jila_pkg::K_OR: r = a | b;
			jila_pkg::K_XOR: r = a ^ b;
			jila_pkg::K_DIV, jila_pkg::K_REM: begin
				if (b == 0)
					o.arith_exception = 1'b1;
				else
					r = quot_or_rem(a, b, k == jila_pkg::K_REM);
			end
			jila_pkg::K_SHL: r = a << sh;
			jila_pkg::K_SHR: r = $signed(a) >>> sh;
			jila_pkg::K_USHR: r = is_long ? a >> sh : {32'd0, a[31:0]} >> sh;
			jila_pkg::K_NEG: r = -a;
			jila_pkg::K_ABS: r = a[63] ? -a : a;
			jila_pkg::K_MIN: r = ($signed(b) < $signed(a)) ? b : a;
			default: r = ($signed(a) < $signed(b)) ? b : a;
		endcase
		o.result_value = is_long ? r : sext_low(r);
		return o;
	endfunction

	initial begin
		errors = 0;
		pending = 0;
	end

	always @(posedge clk) begin
		jila_pkg::out_word_t e;
		if (arst_n && in_valid && in_ready)
			awaited_results.push_back(alu_result(in_word));
		if (arst_n && out_valid && out_ready) begin
			if (awaited_results.size() == 0) begin
				$display("%0t: unexpected result word %h", $realtime, out_word);
				errors++;
			end else begin
				e = awaited_results.pop_front();
				if (e.result_value !== out_word.result_value) begin
					$display("%0t: result_value expected %h actual %h",
						$realtime, e.result_value, out_word.result_value);
					errors++;
				end
				if (e.arith_exception !== out_word.arith_exception) begin
					$display("%0t: arith_exception expected %b actual %b",
						$realtime, e.arith_exception, out_word.arith_exception);
					errors++;
				end
			end
		end
		pending = awaited_results.size();
	end
endmodule

>>> dv/jvm_integer_long_alu_core_tb.sv
// ----------------------------------------------------------------------------
// jvm_integer_long_alu_core_tb
// Drives directed and random operation words into the ALU under varying
// sender and receiver idling, including a long receiver hold-off, and
// reports the verdict from the checker's error count.
// ----------------------------------------------------------------------------
module jvm_integer_long_alu_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	jila_pkg::in_word_t in_word = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	jila_pkg::out_word_t out_word;
	int errors, pending;
	int send_idle = 0, recv_stall = 0;
	bit hold_off = 0;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	jvm_integer_long_alu_core DUT (.*);

	jvm_integer_long_alu_checker checker_i (.*);

	function automatic logic [63:0] rand_operand();
		logic [63:0] v;
		v = {$urandom, $urandom};
		case ($urandom_range(0, 9))
			0: v = 64'd0;
			1: v = 64'h8000_0000_0000_0000;
			2: v = 64'h7FFF_FFFF_FFFF_FFFF;
			3: v = '1;
			4: v = {v[63:32], 32'h8000_0000};
			5: v = {v[63:32], 32'hFFFF_FFFF};
			6: v = 64'($urandom_range(0, 70));
			default: ;
		endcase
		return v;
	endfunction

	always @(posedge clk)
		out_ready <= !hold_off && ($urandom_range(0, 99) >= recv_stall);

	task automatic send(logic [4:0] op, logic [63:0] a, logic [63:0] b);
		while ($urandom_range(0, 99) < send_idle) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_word <= '{operation: op, operand_a: a, operand_b: b};
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
	endtask

	localparam logic [63:0] MIN64 = 64'h8000_0000_0000_0000;
	localparam logic [63:0] MIN32 = 64'h0000_0000_8000_0000;

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		for (int op = 0; op < 32; op++)
			send(op[4:0], rand_operand(), rand_operand());
		send(5'd6, MIN32, '1);
		send(5'd7, MIN32, '1);
		send(5'd21, MIN64, '1);
		send(5'd22, MIN64, '1);
		send(5'd6, 64'd5, 64'hFFFF_FFFF_0000_0000);
		send(5'd22, 64'd5, 64'd0);
		send(5'd26, MIN64, 64'd0);
		send(5'd12, MIN32, 64'd0);
		send(5'd8, 64'd1, 64'hFF);
		send(5'd24, MIN64, 64'hFF);
		send(5'd6, 64'hFFFF_FFF9, 64'd2);
		send(5'd22, -64'd7, 64'd2);
		drain();
		for (int ph = 0; ph < 5; ph++) begin
			case (ph)
				0: begin send_idle = 0; recv_stall = 0; end
				1: begin send_idle = 63; recv_stall = 0; end
				2: begin send_idle = 0; recv_stall = 63; end
				3: begin send_idle = 17; recv_stall = 17; end
				default: begin send_idle = 0; recv_stall = 0; end
			endcase
			if (ph == 4) begin
				hold_off = 1;
				fork
					begin
						repeat (300) @(posedge clk);
						hold_off = 0;
					end
				join_none
			end
			for (int i = 0; i < 140; i++)
				send(5'($urandom_range(0, 31)), rand_operand(), rand_operand());
			drain();
		end
		repeat (80) @(posedge clk);
		if (errors == 0)
			$display("jvm_integer_long_alu_core verification clean");
		else
			$display("jvm_integer_long_alu_core verification failed");
		$finish;
	end

	initial begin
		#2ms;
		$display("jvm_integer_long_alu_core verification failed");
		$finish;
	end
endmodule

>>> filelist.f
rtl/core/jila_pkg.sv
rtl/core/jila_front.sv
rtl/core/jila_div_pipe.sv
rtl/core/jvm_integer_long_alu_core.sv
dv/jvm_integer_long_alu_checker.sv
dv/jvm_integer_long_alu_core_tb.sv
